>>> design/assert_macros.svh
// Assertion helpers for the allocator. Both expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BA_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator assertion failed");
`define BA_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator assertion failed");
`else
`define BA_IMPLY(lbl, ante, cons)
`define BA_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/balloc_pkg.sv
package balloc_pkg;

  localparam int unsigned POOL_ORDER_DEF   = 16;
  localparam int unsigned MIN_ORDER_DEF    = 5;
  localparam int unsigned HEADER_BYTES_DEF = 24;

  localparam int unsigned REQ_W   = 17;
  localparam int unsigned FADDR_W = 16;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned ORD_W   = 5;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_OOM  = 2'd1,
    STAT_IGN  = 2'd2
  } stat_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLR, OP_LOAD, OP_SIZE, OP_SEARCH, OP_SEL, OP_REM_RD, OP_REM_LINK,
    OP_REM_CLR, OP_SPLIT_A, OP_SPLIT_B, OP_PUSH, OP_PUSH_LINK, OP_T_S, OP_RESERVE,
    OP_FCHK, OP_FRD, OP_FEVAL, OP_MRD, OP_T_B, OP_MERGE, OP_MORD, OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    stat_e  stat;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic too_big;
    logic found;
    logic gt;
    logic fbad;
    logic fok;
    logic top;
    logic mok;
  } dp_sts_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_SIZE, ST_SEARCH, ST_SEL, ST_REM_RD, ST_REM_LINK, ST_REM_CLR,
    ST_SPLIT_A, ST_SPLIT_B, ST_PUSH, ST_PUSH_LINK, ST_SEL_S, ST_RESERVE, ST_FCHK,
    ST_FRD, ST_FEVAL, ST_MCHK, ST_MRD, ST_MEVAL, ST_SEL_B, ST_MERGE, ST_MORD, ST_FIN
  } ctrl_state_e;

endpackage

>>> design/balloc_in_if.sv
interface balloc_in_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [balloc_pkg::REQ_W-1:0]    req_size;
  logic [balloc_pkg::FADDR_W-1:0]  free_addr;

  modport source (output valid, kind, req_size, free_addr, input ready);
  modport sink   (input valid, kind, req_size, free_addr, output ready);
endinterface

>>> design/balloc_out_if.sv
interface balloc_out_if;
  logic                          valid;
  logic                          ready;
  logic [balloc_pkg::ADDR_W-1:0] addr;
  logic [1:0]                    status;

  modport source (output valid, addr, status, input ready);
  modport sink   (input valid, addr, status, output ready);
endinterface

>>> design/balloc_ram.sv
module balloc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    addr_i,
  input  logic             we_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/balloc_dp.sv
module balloc_dp #(
  parameter int unsigned POOL_ORDER   = balloc_pkg::POOL_ORDER_DEF,
  parameter int unsigned MIN_ORDER    = balloc_pkg::MIN_ORDER_DEF,
  parameter int unsigned HEADER_BYTES = balloc_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  balloc_pkg::dp_cmd_t            cmd_i,
  output balloc_pkg::dp_sts_t            sts_o,
  input  logic [balloc_pkg::REQ_W-1:0]   req_size_i,
  input  logic [balloc_pkg::FADDR_W-1:0] free_addr_i,
  output logic [balloc_pkg::ADDR_W-1:0]  addr_o,
  output balloc_pkg::stat_e              status_o
);
  import balloc_pkg::*;

  localparam int unsigned SW     = POOL_ORDER - MIN_ORDER;
  localparam int unsigned NSLOTS = 1 << SW;
  localparam int unsigned LW     = SW + 1;
  localparam int unsigned NORD   = SW + 1;
  localparam int unsigned HIW    = (NORD > 1) ? $clog2(NORD) : 1;
  localparam logic [LW-1:0] NONE_LINK = LW'(NSLOTS);

  logic [REQ_W:0]    tot_q;
  logic [FADDR_W-1:0] fa_q;
  logic [ORD_W-1:0]  k_q, o_q;
  logic              too_big_q;
  logic [SW-1:0]     s_q, t_q, b_q, clr_q;
  logic [LW-1:0]     h_q;
  logic [LW-1:0]     heads_q [NORD];
  logic [ADDR_W-1:0] addr_q, res_addr_q;
  stat_e             res_stat_q;

  logic [ORD_W-1:0]  k_calc, j_calc;
  logic              too_big_calc, found;
  logic [HIW-1:0]    hidx;
  logic [LW-1:0]     head_cur;
  logic [31:0]       off32;
  logic              fbad;
  logic [SW-1:0]     fslot, buddy, upper;

  logic [SW-1:0]     res_addr, ord_addr, nxt_addr, prv_addr;
  logic              res_we, ord_we, nxt_we, prv_we;
  logic              res_wd, res_rd;
  logic [ORD_W-1:0]  ord_wd, ord_rd;
  logic [LW-1:0]     nxt_wd, nxt_rd, prv_wd, prv_rd;

  balloc_ram #(.WIDTH(1), .DEPTH(NSLOTS)) u_res_ram (
    .clk_i, .addr_i(res_addr), .we_i(res_we), .wdata_i(res_wd), .rdata_o(res_rd)
  );
  balloc_ram #(.WIDTH(ORD_W), .DEPTH(NSLOTS)) u_ord_ram (
    .clk_i, .addr_i(ord_addr), .we_i(ord_we), .wdata_i(ord_wd), .rdata_o(ord_rd)
  );
  balloc_ram #(.WIDTH(LW), .DEPTH(NSLOTS)) u_nxt_ram (
    .clk_i, .addr_i(nxt_addr), .we_i(nxt_we), .wdata_i(nxt_wd), .rdata_o(nxt_rd)
  );
  balloc_ram #(.WIDTH(LW), .DEPTH(NSLOTS)) u_prv_ram (
    .clk_i, .addr_i(prv_addr), .we_i(prv_we), .wdata_i(prv_wd), .rdata_o(prv_rd)
  );

  // Smallest order whose block holds the request plus header.
  always_comb begin
    k_calc = ORD_W'(POOL_ORDER);
    for (int o = int'(POOL_ORDER); o >= int'(MIN_ORDER); o--) begin
      if (33'(tot_q) <= (33'd1 << o)) begin
        k_calc = ORD_W'(o);
      end
    end
    too_big_calc = 33'(tot_q) > (33'd1 << POOL_ORDER);
  end

  // Lowest non-empty free list at or above the requested order.
  always_comb begin
    found  = 1'b0;
    j_calc = k_q;
    for (int i = int'(NORD) - 1; i >= 0; i--) begin
      if (!heads_q[i][SW] && (ORD_W'(i + int'(MIN_ORDER)) >= k_q)) begin
        found  = 1'b1;
        j_calc = ORD_W'(i + int'(MIN_ORDER));
      end
    end
  end

  assign hidx     = HIW'(o_q - ORD_W'(MIN_ORDER));
  assign head_cur = heads_q[hidx];
  assign off32    = 32'(fa_q) - 32'(HEADER_BYTES);
  assign fbad     = (32'(fa_q) < 32'(HEADER_BYTES)) || (off32[MIN_ORDER-1:0] != '0) ||
                    ((off32 >> POOL_ORDER) != 32'd0);
  assign fslot    = off32[MIN_ORDER +: SW];
  assign buddy    = s_q ^ (SW'(1) << (o_q - ORD_W'(MIN_ORDER)));
  assign upper    = s_q + (SW'(1) << (o_q - ORD_W'(MIN_ORDER + 1)));

  always_comb begin
    sts_o.clr_last = &clr_q;
    sts_o.too_big  = too_big_q;
    sts_o.found    = found;
    sts_o.gt       = o_q > k_q;
    sts_o.fbad     = fbad;
    sts_o.fok      = res_rd && (ord_rd >= ORD_W'(MIN_ORDER)) && (ord_rd <= ORD_W'(POOL_ORDER));
    sts_o.top      = o_q >= ORD_W'(POOL_ORDER);
    sts_o.mok      = (ord_rd == o_q) && !res_rd;
  end

  // Table port control per command.
  always_comb begin
    res_addr = t_q;
    ord_addr = t_q;
    nxt_addr = t_q;
    prv_addr = t_q;
    res_we   = 1'b0;
    ord_we   = 1'b0;
    nxt_we   = 1'b0;
    prv_we   = 1'b0;
    res_wd   = 1'b0;
    ord_wd   = o_q;
    nxt_wd   = NONE_LINK;
    prv_wd   = NONE_LINK;
    unique case (cmd_i.op)
      OP_CLR: begin
        res_addr = clr_q;
        ord_addr = clr_q;
        nxt_addr = clr_q;
        prv_addr = clr_q;
        res_we   = 1'b1;
        ord_we   = 1'b1;
        nxt_we   = 1'b1;
        prv_we   = 1'b1;
        ord_wd   = (clr_q == '0) ? ORD_W'(POOL_ORDER) : '0;
      end
      OP_REM_LINK: begin
        nxt_addr = prv_rd[SW-1:0];
        nxt_we   = !prv_rd[SW];
        nxt_wd   = nxt_rd;
        prv_addr = nxt_rd[SW-1:0];
        prv_we   = !nxt_rd[SW];
        prv_wd   = prv_rd;
      end
      OP_REM_CLR: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
      end
      OP_SPLIT_A: begin
        ord_addr = s_q;
        ord_we   = 1'b1;
        ord_wd   = o_q - ORD_W'(1);
      end
      OP_SPLIT_B, OP_MORD: begin
        ord_we = 1'b1;
      end
      OP_PUSH: begin
        res_we = 1'b1;
        prv_we = 1'b1;
        nxt_we = 1'b1;
        nxt_wd = head_cur;
      end
      OP_PUSH_LINK: begin
        prv_addr = h_q[SW-1:0];
        prv_we   = !h_q[SW];
        prv_wd   = {1'b0, t_q};
      end
      OP_RESERVE: begin
        res_we = 1'b1;
        res_wd = 1'b1;
      end
      OP_MRD: begin
        res_addr = buddy;
        ord_addr = buddy;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      for (int i = 0; i < int'(NORD); i++) begin
        heads_q[i] <= (i == int'(NORD) - 1) ? '0 : NONE_LINK;
      end
    end else begin
      if (cmd_i.op == OP_CLR) begin
        clr_q <= clr_q + SW'(1);
      end
      if (cmd_i.op == OP_REM_LINK && prv_rd[SW]) begin
        heads_q[hidx] <= nxt_rd;
      end
      if (cmd_i.op == OP_PUSH) begin
        heads_q[hidx] <= {1'b0, t_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        tot_q  <= (REQ_W + 1)'(req_size_i) + (REQ_W + 1)'(HEADER_BYTES);
        fa_q   <= free_addr_i;
        addr_q <= '0;
      end
      OP_SIZE: begin
        k_q       <= k_calc;
        too_big_q <= too_big_calc;
      end
      OP_SEARCH: o_q <= j_calc;
      OP_SEL: begin
        s_q <= head_cur[SW-1:0];
        t_q <= head_cur[SW-1:0];
      end
      OP_SPLIT_A: begin
        o_q <= o_q - ORD_W'(1);
        t_q <= upper;
      end
      OP_PUSH: h_q <= head_cur;
      OP_T_S: t_q <= s_q;
      OP_RESERVE: begin
        addr_q <= ADDR_W'((32'(t_q) << MIN_ORDER) + 32'(HEADER_BYTES));
      end
      OP_FCHK: begin
        s_q <= fslot;
        t_q <= fslot;
      end
      OP_FEVAL: o_q <= ord_rd;
      OP_MRD: b_q <= buddy;
      OP_T_B: t_q <= b_q;
      OP_MERGE: begin
        s_q <= (b_q < s_q) ? b_q : s_q;
        t_q <= (b_q < s_q) ? b_q : s_q;
        o_q <= o_q + ORD_W'(1);
      end
      OP_FIN: begin
        res_addr_q <= (cmd_i.stat == STAT_DONE) ? addr_q : '0;
        res_stat_q <= cmd_i.stat;
      end
      default: begin
      end
    endcase
  end

  assign addr_o   = res_addr_q;
  assign status_o = res_stat_q;

endmodule

>>> design/balloc_ctrl.sv
`include "assert_macros.svh"

module balloc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output balloc_pkg::dp_cmd_t cmd_o,
  input  balloc_pkg::dp_sts_t sts_i
);
  import balloc_pkg::*;

  ctrl_state_e state_q, state_d, ret_q, ret_d;
  stat_e       fst_q, fst_d;
  logic        out_valid_q, out_valid_d;
  logic        ld;

  // The result register frees up when empty or when its beat is taken.
  assign ld = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    fst_d   = fst_q;
    unique case (state_q)
      ST_CLR:       if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:      if (in_valid_i) state_d = kind_i ? ST_FCHK : ST_SIZE;
      ST_SIZE:      state_d = ST_SEARCH;
      ST_SEARCH: begin
        if (sts_i.too_big || !sts_i.found) begin
          fst_d   = STAT_OOM;
          state_d = ST_FIN;
        end else begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        ret_d   = sts_i.gt ? ST_SPLIT_A : ST_RESERVE;
        state_d = ST_REM_RD;
      end
      ST_REM_RD:    state_d = ST_REM_LINK;
      ST_REM_LINK:  state_d = ST_REM_CLR;
      ST_REM_CLR:   state_d = ret_q;
      ST_SPLIT_A:   state_d = ST_SPLIT_B;
      ST_SPLIT_B: begin
        ret_d   = ST_SEL_S;
        state_d = ST_PUSH;
      end
      ST_PUSH:      state_d = ST_PUSH_LINK;
      ST_PUSH_LINK: state_d = ret_q;
      ST_SEL_S: begin
        ret_d   = ST_SEL;
        state_d = ST_PUSH;
      end
      ST_RESERVE: begin
        fst_d   = STAT_DONE;
        state_d = ST_FIN;
      end
      ST_FCHK: begin
        if (sts_i.fbad) begin
          fst_d   = STAT_IGN;
          state_d = ST_FIN;
        end else begin
          state_d = ST_FRD;
        end
      end
      ST_FRD:       state_d = ST_FEVAL;
      ST_FEVAL: begin
        if (!sts_i.fok) begin
          fst_d   = STAT_IGN;
          state_d = ST_FIN;
        end else begin
          ret_d   = ST_MCHK;
          state_d = ST_PUSH;
        end
      end
      ST_MCHK: begin
        if (sts_i.top) begin
          fst_d   = STAT_DONE;
          state_d = ST_FIN;
        end else begin
          state_d = ST_MRD;
        end
      end
      ST_MRD:       state_d = ST_MEVAL;
      ST_MEVAL: begin
        if (!sts_i.mok) begin
          fst_d   = STAT_DONE;
          state_d = ST_FIN;
        end else begin
          ret_d   = ST_SEL_B;
          state_d = ST_REM_RD;
        end
      end
      ST_SEL_B: begin
        ret_d   = ST_MERGE;
        state_d = ST_REM_RD;
      end
      ST_MERGE:     state_d = ST_MORD;
      ST_MORD: begin
        ret_d   = ST_MCHK;
        state_d = ST_PUSH;
      end
      ST_FIN:       if (ld) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_NOP;
    cmd_o.stat = fst_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLR:       cmd_o.op = OP_CLR;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_SIZE:      cmd_o.op = OP_SIZE;
      ST_SEARCH:    cmd_o.op = OP_SEARCH;
      ST_SEL:       cmd_o.op = OP_SEL;
      ST_REM_RD:    cmd_o.op = OP_REM_RD;
      ST_REM_LINK:  cmd_o.op = OP_REM_LINK;
      ST_REM_CLR:   cmd_o.op = OP_REM_CLR;
      ST_SPLIT_A:   cmd_o.op = OP_SPLIT_A;
      ST_SPLIT_B:   cmd_o.op = OP_SPLIT_B;
      ST_PUSH:      cmd_o.op = OP_PUSH;
      ST_PUSH_LINK: cmd_o.op = OP_PUSH_LINK;
      ST_SEL_S:     cmd_o.op = OP_T_S;
      ST_RESERVE:   cmd_o.op = OP_RESERVE;
      ST_FCHK:      cmd_o.op = OP_FCHK;
      ST_FRD:       cmd_o.op = OP_FRD;
      ST_FEVAL:     cmd_o.op = OP_FEVAL;
      ST_MRD:       cmd_o.op = OP_MRD;
      ST_SEL_B:     cmd_o.op = OP_T_B;
      ST_MERGE:     cmd_o.op = OP_MERGE;
      ST_MORD:      cmd_o.op = OP_MORD;
      ST_FIN:       if (ld) cmd_o.op = OP_FIN;
      default:      cmd_o.op = OP_NOP;
    endcase
  end

  assign out_valid_d = ld || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      ret_q       <= ST_IDLE;
      fst_q       <= STAT_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      fst_q       <= fst_d;
      out_valid_q <= out_valid_d;
    end
  end

  `BA_IMPLY(a_no_accept_in_clear, state_q == ST_CLR, !in_ready_o)
  `BA_IMPLY(a_load_into_free_reg, ld, !out_valid_q || out_ready_i)
  `BA_NEXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != ST_IDLE)
  `BA_NEXT(a_load_sets_valid, ld, out_valid_q)

endmodule

>>> design/buddy_allocator.sv
// Channel   Dir  Payload                      Beat
// in_if     in   kind, req_size, free_addr    one allocate or free request
// out_if    out  addr, status                 one result per request
//
// One request at a time, driven by a sequencer over four single-port slot tables.
// Allocation time grows with each split level and free time with each merge level.
// After reset a clearing pass runs over every slot table entry before the first
// request is taken.
// The next request is accepted while a finished result waits on out_if; the one after
// that stalls until the waiting beat is taken.
module buddy_allocator #(
  parameter int unsigned POOL_ORDER   = balloc_pkg::POOL_ORDER_DEF,
  parameter int unsigned MIN_ORDER    = balloc_pkg::MIN_ORDER_DEF,
  parameter int unsigned HEADER_BYTES = balloc_pkg::HEADER_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  balloc_in_if.sink    in_if,
  balloc_out_if.source out_if
);
  import balloc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  stat_e   status;

  balloc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .kind_i      (in_if.kind),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  balloc_dp #(
    .POOL_ORDER   (POOL_ORDER),
    .MIN_ORDER    (MIN_ORDER),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_size_i  (in_if.req_size),
    .free_addr_i (in_if.free_addr),
    .addr_o      (out_if.addr),
    .status_o    (status)
  );

  assign out_if.status = status;

endmodule
